>>> src/dtl_pkg.sv
`default_nettype none
package dtl_pkg;
  localparam int MAX_NODES_DEF = 1024;
  localparam int LIFT_LEVELS_DEF = 10;
  localparam int ID_W = 10;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef struct packed {
    req_t req;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    logic bad;
  } cmd_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RD_DA, S_RD_DB, S_WAIT_D, S_CMP,
    S_CLIMB_RD, S_CLIMB_WT, S_SAME_CHK, S_SAME_RD, S_SAME_WT, S_SAME_DEP, S_SAME_END,
    S_SAME_END_WT, S_UP_RD, S_UP_WT, S_CMP_RD, S_CMP_WT, S_CMP_W, S_OUT,
    S_ADD_RD, S_ADD_WT, S_ADD_LOOP, S_ADD_RDK, S_ADD_WTK, S_RM_RD, S_RM_WT,
    S_RM_RD2, S_RM_WT2
  } state_t;
endpackage
`default_nettype wire

>>> src/dynamic_tree_lca_alive.sv
// A request is queued by the front, then taken by the back end once it is idle and its result
// register is free; a query fetches both depths, climbs the deeper node, climbs both in step,
// finds the nearest alive ancestor of the lca and rewrites the dead links on the way; bad ids answer at once.
// The back end holds one request at a time: an add writes the depth, link and ancestor entries,
// a remove rewrites one link. A two-entry queue decouples the front.
// Reset: synchronous rst leaves the root alone; an init pass then writes its entries.
`default_nettype none
module dynamic_tree_lca_alive #(
  parameter int MAX_NODES = dtl_pkg::MAX_NODES_DEF,
  parameter int LIFT_LEVELS = dtl_pkg::LIFT_LEVELS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [1:0] req_type,
  input wire logic [dtl_pkg::ID_W-1:0] node_a,
  input wire logic [dtl_pkg::ID_W-1:0] node_b,
  output logic out_valid,
  input wire logic out_ready,
  output logic [dtl_pkg::ID_W-1:0] common_id,
  output logic error
);
  // front checks ids against its own count and drops requests that do nothing
  logic q_valid, q_ready;
  dtl_pkg::cmd_t q_cmd;

  dtl_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .node_a, .node_b,
    .q_valid, .q_ready, .q_cmd
  );

  // back walks the tables and holds the result register
  dtl_back #(.MAX_NODES(MAX_NODES), .LIFT_LEVELS(LIFT_LEVELS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .common_id, .error
  );
endmodule
`default_nettype wire

>>> src/dtl_ram.sv
`default_nettype none
module dtl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/dtl_front.sv
`default_nettype none
module dtl_front #(
  parameter int MAX_NODES = dtl_pkg::MAX_NODES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [1:0] req_type,
  input wire logic [dtl_pkg::ID_W-1:0] node_a,
  input wire logic [dtl_pkg::ID_W-1:0] node_b,
  output logic q_valid,
  input wire logic q_ready,
  output dtl_pkg::cmd_t q_cmd
);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int PW = $clog2(dtl_pkg::QDEPTH);
  // front keeps its own node count, tracking adds that will succeed
  logic [CW-1:0] count;
  dtl_pkg::cmd_t fifo [dtl_pkg::QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0] used;
  dtl_pkg::cmd_t c;
  logic push, pop, keep;
  logic [CW-1:0] ea, eb;

  assign in_ready = (used != (PW+1)'(dtl_pkg::QDEPTH));
  assign q_valid = (used != '0);
  assign q_cmd = fifo[rp];
  assign pop = q_valid && q_ready;

  always_comb begin
    ea = CW'(node_a);
    eb = CW'(node_b);
    c.req = dtl_pkg::req_t'(req_type);
    c.a = node_a;
    c.b = node_b;
    c.bad = 1'b0;
    keep = 1'b0;
    case (c.req)
      dtl_pkg::REQ_ADD: keep = (count < CW'(MAX_NODES)) && (ea < count);
      dtl_pkg::REQ_REMOVE: keep = (node_a != '0) && (ea < count);
      dtl_pkg::REQ_QUERY: begin
        keep = 1'b1;
        c.bad = (ea >= count) || (eb >= count);
      end
      default: keep = 1'b0;
    endcase
  end
  assign push = in_valid && in_ready && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
      wp <= '0;
      rp <= '0;
      used <= '0;
    end else begin
      if (push) begin
        fifo[wp] <= c;
        wp <= wp + PW'(1);
        if (c.req == dtl_pkg::REQ_ADD) count <= count + CW'(1);
      end
      if (pop) rp <= rp + PW'(1);
      used <= used + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> src/dtl_back.sv
`default_nettype none
module dtl_back #(
  parameter int MAX_NODES = dtl_pkg::MAX_NODES_DEF,
  parameter int LIFT_LEVELS = dtl_pkg::LIFT_LEVELS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic q_valid,
  output logic q_ready,
  input wire dtl_pkg::cmd_t q_cmd,
  output logic out_valid,
  input wire logic out_ready,
  output logic [dtl_pkg::ID_W-1:0] common_id,
  output logic error
);
  localparam int IW = dtl_pkg::ID_W;
  localparam int NW = $clog2(MAX_NODES);
  localparam int KW = $clog2(LIFT_LEVELS + 1);
  localparam int AD = MAX_NODES * LIFT_LEVELS;
  localparam int AW = $clog2(AD);
  localparam int CW = $clog2(MAX_NODES + 1);

  dtl_pkg::state_t state, state_next;
  logic [IW-1:0] a, b, a_next, b_next;
  logic [IW-1:0] h, h_next, da, da_next, top, top_next;
  logic [IW-1:0] pa, pa_next;
  logic [KW-1:0] k, k_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] res, res_next;
  logic res_err, res_err_next, ov, ov_next;

  logic an_we, dp_we, lk_we;
  logic [AW-1:0] an_wa, an_ra;
  logic [NW-1:0] dp_wa, dp_ra, lk_wa, lk_ra;
  logic [IW-1:0] an_wd, an_rd, dp_wd, dp_rd, lk_wd, lk_rd;

  dtl_ram #(.WIDTH(IW), .DEPTH(AD)) u_anc (.clk, .we(an_we), .waddr(an_wa),
    .wdata(an_wd), .raddr(an_ra), .rdata(an_rd));
  dtl_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_dep (.clk, .we(dp_we), .waddr(dp_wa),
    .wdata(dp_wd), .raddr(dp_ra), .rdata(dp_rd));
  dtl_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_lnk (.clk, .we(lk_we), .waddr(lk_wa),
    .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));

  function automatic logic [AW-1:0] aidx(input logic [IW-1:0] n, input logic [KW-1:0] kk);
    logic [AW+IW-1:0] t;
    t = (AW+IW)'(n) * (AW+IW)'(LIFT_LEVELS) + (AW+IW)'(kk);
    return t[AW-1:0];
  endfunction

  function automatic logic [KW-1:0] flog(input logic [IW-1:0] v);
    logic [KW-1:0] r;
    r = '0;
    for (int i = 1; i < IW; i++)
      if (v[i]) r = KW'(i);
    if (32'(r) > LIFT_LEVELS - 1) r = KW'(LIFT_LEVELS - 1);
    return r;
  endfunction

  assign out_valid = ov;
  assign common_id = res;
  assign error = res_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtl_pkg::S_INIT;
      ov <= 1'b0;
      count <= CW'(1);
      k <= '0;
    end else begin
      state <= state_next;
      ov <= ov_next;
      count <= count_next;
      k <= k_next;
    end
    a <= a_next; b <= b_next; h <= h_next; da <= da_next; top <= top_next;
    pa <= pa_next; res <= res_next; res_err <= res_err_next;
  end

  always_comb begin
    state_next = state;
    a_next = a; b_next = b; h_next = h; da_next = da; top_next = top;
    pa_next = pa; k_next = k; count_next = count;
    res_next = res; res_err_next = res_err;
    ov_next = ov && !out_ready;
    q_ready = 1'b0;
    an_we = 1'b0; an_wa = aidx(a, '0); an_wd = an_rd; an_ra = aidx(a, k);
    dp_we = 1'b0; dp_wa = NW'(a); dp_wd = dp_rd; dp_ra = NW'(a);
    lk_we = 1'b0; lk_wa = NW'(a); lk_wd = top; lk_ra = NW'(a);
    case (state)
      // write the root's entries: ancestors and depth zero, link to itself
      dtl_pkg::S_INIT: begin
        an_we = 1'b1; an_wa = aidx('0, k); an_wd = '0;
        dp_we = 1'b1; dp_wa = '0; dp_wd = '0;
        lk_we = 1'b1; lk_wa = '0; lk_wd = '0;
        k_next = k + KW'(1);
        if (32'(k) >= LIFT_LEVELS - 1) state_next = dtl_pkg::S_IDLE;
      end
      dtl_pkg::S_IDLE: begin
        q_ready = !ov || out_ready;
        if (q_valid && q_ready) begin
          a_next = q_cmd.a;
          b_next = q_cmd.b;
          case (q_cmd.req)
            dtl_pkg::REQ_ADD: state_next = dtl_pkg::S_ADD_RD;
            dtl_pkg::REQ_REMOVE: state_next = dtl_pkg::S_RM_RD;
            dtl_pkg::REQ_QUERY: begin
              if (q_cmd.bad) begin
                res_next = '0; res_err_next = 1'b1; ov_next = 1'b1;
              end else state_next = dtl_pkg::S_RD_DA;
            end
            default: state_next = dtl_pkg::S_IDLE;
          endcase
        end
      end
      // query: fetch both depths
      dtl_pkg::S_RD_DA: begin dp_ra = NW'(a); state_next = dtl_pkg::S_RD_DB; end
      dtl_pkg::S_RD_DB: begin
        dp_ra = NW'(b); da_next = dp_rd; state_next = dtl_pkg::S_WAIT_D;
      end
      dtl_pkg::S_WAIT_D: begin h_next = dp_rd; state_next = dtl_pkg::S_CMP; end
      dtl_pkg::S_CMP: begin
        // keep a the shallower; h holds depth of b, da depth of a
        if (da > h) begin
          a_next = b; b_next = a; da_next = h; h_next = da;
        end
        state_next = dtl_pkg::S_CLIMB_RD;
      end
      dtl_pkg::S_CLIMB_RD: begin
        if (h > da) begin
          k_next = flog(h - da);
          an_ra = aidx(b, flog(h - da));
          state_next = dtl_pkg::S_CLIMB_WT;
        end else begin
          h_next = da;
          state_next = dtl_pkg::S_SAME_CHK;
        end
      end
      dtl_pkg::S_CLIMB_WT: begin
        b_next = an_rd; dp_ra = NW'(an_rd); state_next = dtl_pkg::S_SAME_DEP;
        top_next = '1; // marks climb phase
      end
      dtl_pkg::S_SAME_DEP: begin
        if (top == '1) begin
          h_next = dp_rd; state_next = dtl_pkg::S_CLIMB_RD;
        end else begin
          h_next = dp_rd; state_next = dtl_pkg::S_SAME_CHK;
        end
      end
      dtl_pkg::S_SAME_CHK: begin
        top_next = '0;
        if (a != b && h != '0) begin
          k_next = flog(h);
          an_ra = aidx(a, flog(h));
          state_next = dtl_pkg::S_SAME_RD;
        end else if (a == b) begin
          state_next = dtl_pkg::S_UP_RD;
        end else begin
          an_ra = aidx(a, '0);
          state_next = dtl_pkg::S_SAME_END;
        end
      end
      dtl_pkg::S_SAME_RD: begin
        pa_next = an_rd; an_ra = aidx(b, k); state_next = dtl_pkg::S_SAME_WT;
      end
      dtl_pkg::S_SAME_WT: begin
        if (pa != an_rd) begin
          a_next = pa; b_next = an_rd; dp_ra = NW'(pa);
          state_next = dtl_pkg::S_SAME_DEP;
        end else begin
          h_next = h >> 1; state_next = dtl_pkg::S_SAME_CHK;
        end
      end
      dtl_pkg::S_SAME_END: begin an_ra = aidx(a, '0); state_next = dtl_pkg::S_SAME_END_WT; end
      dtl_pkg::S_SAME_END_WT: begin a_next = an_rd; state_next = dtl_pkg::S_UP_RD; end
      // nearest alive: top starts at lca
      dtl_pkg::S_UP_RD: begin
        top_next = a; b_next = a; lk_ra = NW'(a); state_next = dtl_pkg::S_UP_WT;
      end
      dtl_pkg::S_UP_WT: begin
        lk_ra = NW'(lk_rd);
        if (lk_rd == top) state_next = dtl_pkg::S_CMP_RD;
        else begin top_next = lk_rd; state_next = dtl_pkg::S_UP_WT; end
      end
      // compress: walk from lca (b) to top, rewriting links
      dtl_pkg::S_CMP_RD: begin lk_ra = NW'(b); state_next = dtl_pkg::S_CMP_WT; end
      dtl_pkg::S_CMP_WT: begin
        if (b == top) begin
          res_next = top; res_err_next = 1'b0; ov_next = 1'b1;
          state_next = dtl_pkg::S_OUT;
        end else begin
          lk_we = 1'b1; lk_wa = NW'(b); lk_wd = top;
          b_next = lk_rd; state_next = dtl_pkg::S_CMP_RD;
        end
      end
      dtl_pkg::S_OUT: state_next = dtl_pkg::S_IDLE;
      // add: depth, link, ancestors
      dtl_pkg::S_ADD_RD: begin dp_ra = NW'(a); state_next = dtl_pkg::S_ADD_WT; end
      dtl_pkg::S_ADD_WT: begin
        dp_we = 1'b1; dp_wa = NW'(count); dp_wd = dp_rd + IW'(1);
        lk_we = 1'b1; lk_wa = NW'(count); lk_wd = IW'(count);
        an_we = 1'b1; an_wa = aidx(IW'(count), '0); an_wd = a;
        pa_next = a; k_next = KW'(1);
        state_next = dtl_pkg::S_ADD_LOOP;
      end
      dtl_pkg::S_ADD_LOOP: begin
        if (32'(k) >= LIFT_LEVELS) begin
          count_next = count + CW'(1); state_next = dtl_pkg::S_IDLE;
        end else begin
          an_ra = aidx(pa, k - KW'(1)); state_next = dtl_pkg::S_ADD_RDK;
        end
      end
      dtl_pkg::S_ADD_RDK: begin
        an_ra = aidx(pa, k - KW'(1)); state_next = dtl_pkg::S_ADD_WTK;
      end
      dtl_pkg::S_ADD_WTK: begin
        an_we = 1'b1; an_wa = aidx(IW'(count), k); an_wd = an_rd;
        pa_next = an_rd; k_next = k + KW'(1);
        state_next = dtl_pkg::S_ADD_LOOP;
      end
      // remove: link[a] = link[parent(a)]
      dtl_pkg::S_RM_RD: begin an_ra = aidx(a, '0); state_next = dtl_pkg::S_RM_WT; end
      dtl_pkg::S_RM_WT: begin an_ra = aidx(a, '0); state_next = dtl_pkg::S_RM_RD2; end
      dtl_pkg::S_RM_RD2: begin lk_ra = NW'(an_rd); state_next = dtl_pkg::S_RM_WT2; end
      dtl_pkg::S_RM_WT2: begin
        lk_we = 1'b1; lk_wa = NW'(a); lk_wd = lk_rd; state_next = dtl_pkg::S_IDLE;
      end
      default: state_next = dtl_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> bench/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = dtl_pkg::MAX_NODES_DEF;
  localparam int LEVELS = dtl_pkg::LIFT_LEVELS_DEF;
  localparam int RANDOM_REQS = 300;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    dtl_pkg::req_t op;
    logic [dtl_pkg::ID_W-1:0] a;
    logic [dtl_pkg::ID_W-1:0] b;
  } tree_req_t;

  typedef struct {
    logic [dtl_pkg::ID_W-1:0] lca;
    logic err;
  } lca_answer_t;

  // Directed row: request plus an optional answer typed in by hand
  typedef struct {
    dtl_pkg::req_t op;
    logic [dtl_pkg::ID_W-1:0] a;
    logic [dtl_pkg::ID_W-1:0] b;
    bit typed;
    logic [dtl_pkg::ID_W-1:0] lca;
    logic err;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = dtl_pkg::REQ_NONE;
  logic [dtl_pkg::ID_W-1:0] node_a = '0;
  logic [dtl_pkg::ID_W-1:0] node_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [dtl_pkg::ID_W-1:0] common_id;
  logic error;

  dynamic_tree_lca_alive DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .node_a(node_a), .node_b(node_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .common_id(common_id), .error(error)
  );

  always #5 clk = ~clk;

  // Shadow copy of the tree: lifting table, depths, alive links, node count
  logic [dtl_pkg::ID_W-1:0] lift_up [NODES][LEVELS];
  logic [dtl_pkg::ID_W-1:0] tree_depth [NODES];
  logic [dtl_pkg::ID_W-1:0] alive_up [NODES];
  int tree_size = 1;

  lca_answer_t pending_answers [$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;

  task automatic report(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int lift_step(int span);
    int lg;
    lg = 0;
    while (span > 1) begin
      span = span >> 1;
      lg++;
    end
    return (lg > LEVELS - 1) ? LEVELS - 1 : lg;
  endfunction

  // Follow alive links to the nearest live node, then point the whole dead
  // chain straight at it
  function automatic int live_ancestor(int n);
    int top, guard, nxt;
    top = n;
    guard = 0;
    while (alive_up[top] != top && guard < NODES) begin
      top = alive_up[top];
      guard++;
    end
    guard = 0;
    while (n != top && guard < NODES) begin
      nxt = alive_up[n];
      alive_up[n] = dtl_pkg::ID_W'(top);
      n = nxt;
      guard++;
    end
    return top;
  endfunction

  function automatic int lowest_common(int a, int b);
    int t, h, pa, pb;
    if (tree_depth[a] > tree_depth[b]) begin
      t = a;
      a = b;
      b = t;
    end
    // lift the deeper node to the shallower one's depth
    while (tree_depth[b] > tree_depth[a])
      b = lift_up[b][lift_step(tree_depth[b] - tree_depth[a])];
    h = tree_depth[a];
    while (a != b && h > 0) begin
      pa = lift_up[a][lift_step(h)];
      pb = lift_up[b][lift_step(h)];
      if (pa != pb) begin
        a = pa;
        b = pb;
        h = tree_depth[a];
      end else begin
        h = h >> 1;
      end
    end
    return (a == b) ? a : lift_up[a][0];
  endfunction

  // Apply one accepted request to the shadow tree; true when an answer is due
  function automatic bit apply_request(tree_req_t r, output lca_answer_t ans);
    int id;
    ans.lca = '0;
    ans.err = 1'b0;
    case (r.op)
      dtl_pkg::REQ_ADD: begin
        if (tree_size < NODES && r.a < tree_size) begin
          id = tree_size;
          tree_depth[id] = dtl_pkg::ID_W'(tree_depth[r.a] + 1);
          alive_up[id] = dtl_pkg::ID_W'(id);
          lift_up[id][0] = r.a;
          for (int k = 1; k < LEVELS; k++)
            lift_up[id][k] = lift_up[lift_up[id][k-1]][k-1];
          tree_size++;
        end
        return 1'b0;
      end
      dtl_pkg::REQ_REMOVE: begin
        if (r.a != 0 && r.a < tree_size)
          alive_up[r.a] = alive_up[lift_up[r.a][0]];
        return 1'b0;
      end
      dtl_pkg::REQ_QUERY: begin
        if (r.a >= tree_size || r.b >= tree_size)
          ans.err = 1'b1;
        else
          ans.lca = dtl_pkg::ID_W'(live_ancestor(lowest_common(r.a, r.b)));
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [dtl_pkg::ID_W-1:0] known_id();
    return dtl_pkg::ID_W'($urandom_range(0, tree_size - 1));
  endfunction

  // Mostly well-formed requests on existing ids; adds lean on recent nodes
  // so the tree grows deep, with some noise on unknown ids and unused codes
  function automatic tree_req_t random_request();
    tree_req_t r;
    int pick, back;
    pick = $urandom_range(0, 99);
    r.a = dtl_pkg::ID_W'($urandom);
    r.b = dtl_pkg::ID_W'($urandom);
    if (pick < 40) begin
      r.op = dtl_pkg::REQ_ADD;
      pick = $urandom_range(0, 99);
      back = (tree_size > 4) ? 3 : tree_size - 1;
      if (pick < 60) r.a = dtl_pkg::ID_W'(tree_size - 1 - $urandom_range(0, back));
      else if (pick < 92) r.a = known_id();
    end else if (pick < 65) begin
      r.op = dtl_pkg::REQ_REMOVE;
      pick = $urandom_range(0, 99);
      if (pick < 10) r.a = '0;
      else if (pick < 85) r.a = known_id();
    end else if (pick < 96) begin
      r.op = dtl_pkg::REQ_QUERY;
      if ($urandom_range(0, 99) < 85) begin
        r.a = known_id();
        r.b = known_id();
      end
    end else begin
      r.op = dtl_pkg::REQ_NONE;
    end
    return r;
  endfunction

  // Offer one request in bursts with random gaps; called just after a rising edge
  task automatic send(tree_req_t r, bit typed, lca_answer_t typed_ans);
    int gap;
    lca_answer_t ans;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= r.op;
    node_a <= r.a;
    node_b <= r.b;
    do @(posedge clk); while (!in_ready);
    if (apply_request(r, ans))
      pending_answers.insert(pending_answers.size(), typed ? typed_ans : ans);
  endtask

  // Receiver: stall pattern is redrawn at random from three modes; one long hold-off so
  // the internal queue fills and the input side backs up
  int rx_cycles = 0;
  int rx_mode = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    rx_cycles++;
    if (rx_cycles % 64 == 0) rx_mode = $urandom_range(0, 2);
    if (rx_cycles == 3000) hold_left = 800;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check each delivered answer against the oldest one pending
  always @(posedge clk) begin
    lca_answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report($sformatf("unexpected answer lca=%0d err=%0b", common_id, error));
      end else begin
        want = pending_answers.pop_front();
        if (error !== want.err)
          report($sformatf("error flag %0b, want %0b", error, want.err));
        if (common_id !== want.lca)
          report($sformatf("common_id %0d, want %0d", common_id, want.lca));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("dynamic_tree_lca_alive test failed");
      $finish;
    end
  end

  // Directed part: empty-tree answers, unknown ids, root and unknown removals,
  // repeated removal, an unused code, then a small tree with dead chains
  directed_row_t directed [] = '{
    '{dtl_pkg::REQ_QUERY,  10'd0,    10'd0,    1'b1, 10'd0, 1'b0},
    '{dtl_pkg::REQ_QUERY,  10'd1,    10'd0,    1'b1, 10'd0, 1'b1},
    '{dtl_pkg::REQ_QUERY,  10'd0,    10'd1023, 1'b1, 10'd0, 1'b1},
    '{dtl_pkg::REQ_QUERY,  10'd1023, 10'd1023, 1'b1, 10'd0, 1'b1},
    '{dtl_pkg::REQ_REMOVE, 10'd0,    10'd0,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_REMOVE, 10'd5,    10'd0,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_ADD,    10'd5,    10'd0,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_NONE,   10'd1023, 10'd1023, 1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_ADD,    10'd0,    10'd1023, 1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_ADD,    10'd1,    10'd0,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_ADD,    10'd2,    10'd0,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_ADD,    10'd1,    10'd0,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_ADD,    10'd3,    10'd0,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_QUERY,  10'd3,    10'd4,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_QUERY,  10'd5,    10'd4,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_REMOVE, 10'd1,    10'd0,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_REMOVE, 10'd2,    10'd0,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_REMOVE, 10'd3,    10'd0,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_QUERY,  10'd5,    10'd4,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_QUERY,  10'd5,    10'd5,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_REMOVE, 10'd1,    10'd0,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_QUERY,  10'd3,    10'd3,    1'b0, 10'd0, 1'b0},
    '{dtl_pkg::REQ_QUERY,  10'd0,    10'd5,    1'b1, 10'd0, 1'b0}
  };

  initial begin
    tree_req_t r;
    lca_answer_t typed_ans;
    lift_up[0] = '{default: '0};
    tree_depth[0] = '0;
    alive_up[0] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      r.op = directed[i].op;
      r.a = directed[i].a;
      r.b = directed[i].b;
      typed_ans.lca = directed[i].lca;
      typed_ans.err = directed[i].err;
      send(r, directed[i].typed, typed_ans);
    end

    for (int i = 0; i < RANDOM_REQS; i++)
      send(random_request(), 1'b0, typed_ans);

    // Fill the store, then hit it with random requests, whose adds must be dropped
    while (tree_size < NODES) begin
      r.op = ($urandom_range(0, 15) == 0) ? dtl_pkg::REQ_QUERY : dtl_pkg::REQ_ADD;
      r.a = dtl_pkg::ID_W'(tree_size - 1 -
                           $urandom_range(0, (tree_size > 8) ? 7 : tree_size - 1));
      r.b = known_id();
      send(r, 1'b0, typed_ans);
    end
    for (int i = 0; i < 40; i++) begin
      r = random_request();
      send(r, 1'b0, typed_ans);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("dynamic_tree_lca_alive test passed");
    else
      $display("dynamic_tree_lca_alive test failed");
    $finish;
  end
endmodule
`default_nettype wire
